@@ design/w3f_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3f_pkg
// Types, constants and arithmetic helpers of the 3x3 weighted pixel filter.
// ----------------------------------------------------------------------------
package w3f_pkg;

    localparam int MAX_DIM = 1024;
    localparam int CW      = $clog2(MAX_DIM);   // row / column width
    localparam int FSW     = 11;                // frame_size register width
    localparam int CHW     = 16;                // channel width
    localparam int PW      = 3 * CHW;           // packed pixel width
    localparam int PRODW   = 22;                // channel * weight
    localparam int AW      = 2;                 // APB address width

    localparam logic [AW-1:0]  REG_FRAME_SIZE = 2'd0;
    localparam logic [FSW-1:0] FRAME_SIZE_RST = 11'd512;

    // reciprocal of 100: exact floor for any 22-bit dividend
    localparam logic [22:0] RECIP_100 = 23'd5368710;
    localparam int          RECIP_SH  = 29;

    // weights in hundredths
    localparam logic [5:0] KW [3][3] = '{'{6'd60, 6'd3,  6'd0},
                                        '{6'd3,  6'd30, 6'd3},
                                        '{6'd0,  6'd3,  6'd10}};

    typedef logic [PW-1:0]          t_pix;      // {blue, green, red}
    typedef t_pix [2:0][2:0]        t_win;      // [window row][window col]

    typedef struct packed {
        logic [CHW-1:0] in_red;
        logic [CHW-1:0] in_green;
        logic [CHW-1:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [CW-1:0]  out_row;
        logic [CW-1:0]  out_col;
        logic [CHW-1:0] out_red;
        logic [CHW-1:0] out_green;
        logic [CHW-1:0] out_blue;
        logic           burst_end;
    } t_out_item;

    // one output to compute: position and where it sits in the window
    typedef struct packed {
        logic          vld;
        logic [CW-1:0] row;
        logic [CW-1:0] col;
        logic          last;
        logic [1:0]    oa;      // window row holding image row 'row'
        logic [1:0]    ob;      // window col holding image col 'col'
    } t_job;

    function automatic logic [5:0] weight(input logic [1:0] oa, input logic [1:0] ob,
                                          input logic [1:0] wr, input logic [1:0] wc);
        logic [1:0] di;
        logic [1:0] dj;
        di = wr - oa;
        dj = wc - ob;
        if (wr >= oa && wc >= ob) begin
            return KW[di][dj];
        end
        return 6'd0;
    endfunction

    function automatic logic [CHW-1:0] div100(input logic [PRODW-1:0] x);
        logic [44:0] p;
        p = {23'b0, x} * {22'b0, RECIP_100};
        return p[RECIP_SH +: CHW];
    endfunction

endpackage

@@ design/weighted_3x3_pixel_filter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_3x3_pixel_filter_core
// 3x3 weighted filter over a square RGB raster stream, two line buffers.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------
//  input    | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  output   | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  config   | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
//  One pixel per cycle while each pixel causes at most one output and the
//  output is not stalled; a pixel in the last row or column causing k
//  outputs holds the input until the single output sequencer issues all k.
//  Output valid comes from the kernel, after stage one and the sequencer.
//  Reset clears control and r_win; line buffer entries are never cleared.
//  An output stall with output valid freezes the whole result pipeline.
module weighted_3x3_pixel_filter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  w3f_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output w3f_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [w3f_pkg::AW-1:0]        paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import w3f_pkg::*;

    logic [FSW-1:0]  r_fs;
    logic [CW-1:0]   r_row, r_col;
    logic [FSW-1:0]  n_eff;
    logic [CW-1:0]   nm1, acc_r, acc_c;
    logic            cfg_wr, accept, consume, en;

    logic            r_s1_v;
    t_pix            r_s1_pix;
    logic [CW-1:0]   r_s1_r, r_s1_c;
    logic [2*PW-1:0] mem [MAX_DIM];
    logic [2*PW-1:0] r_rd, r_byp_d, rd_eff;
    logic            r_byp;

    t_win            r_win;
    logic            r_em_busy;
    logic [CW-1:0]   r_ea, r_eb, r_eb0, r_ea1, r_eb1, r_er, r_ec;
    logic            em_last;
    logic [CW-1:0]   a0, a1, b0, b1;
    logic            has_a, has_b;
    t_job            job;
    logic            kern_v;

    assign pready = 1'b1;
    assign prdata = {{(32-FSW){1'b0}}, r_fs};
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_FRAME_SIZE);

    always_comb begin
        if (r_fs == '0)                     n_eff = FSW'(1);
        else if (r_fs > FSW'(MAX_DIM))      n_eff = FSW'(MAX_DIM);
        else                                n_eff = r_fs;
    end
    assign nm1 = CW'(n_eff - FSW'(1));

    // a position left outside the frame restarts it
    always_comb begin
        if (r_row > nm1 || r_col > nm1) begin
            acc_r = '0;
            acc_c = '0;
        end else begin
            acc_r = r_row;
            acc_c = r_col;
        end
    end

    assign en      = !o_out_valid || !i_out_stall;
    assign em_last = (r_ea == r_ea1) && (r_eb == r_eb1);
    assign consume = r_s1_v && (!r_em_busy || (en && em_last));
    assign o_in_stall = r_s1_v && !consume;
    assign accept  = i_in_valid && !o_in_stall;
    assign rd_eff  = r_byp ? r_byp_d : r_rd;

    // outputs completed by the pixel in stage one
    always_comb begin
        has_a = 1'b1;
        a0 = '0;
        a1 = '0;
        priority if (r_s1_r == nm1) begin
            a0 = (r_s1_r >= CW'(2)) ? r_s1_r - CW'(2) : '0;
            a1 = r_s1_r;
        end else if (r_s1_r >= CW'(2)) begin
            a0 = r_s1_r - CW'(2);
            a1 = a0;
        end else begin
            has_a = 1'b0;
        end
        has_b = 1'b1;
        b0 = '0;
        b1 = '0;
        priority if (r_s1_c == nm1) begin
            b0 = (r_s1_c >= CW'(2)) ? r_s1_c - CW'(2) : '0;
            b1 = r_s1_c;
        end else if (r_s1_c >= CW'(2)) begin
            b0 = r_s1_c - CW'(2);
            b1 = b0;
        end else begin
            has_b = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs      <= FRAME_SIZE_RST;
            r_row     <= '0;
            r_col     <= '0;
            r_s1_v    <= 1'b0;
            r_byp     <= 1'b0;
            r_em_busy <= 1'b0;
            r_win     <= '0;
        end else begin
            if (cfg_wr) begin
                r_fs  <= pwdata[FSW-1:0];
                r_row <= '0;
                r_col <= '0;
            end else if (accept) begin
                if (acc_c == nm1) begin
                    r_col <= '0;
                    r_row <= (acc_r == nm1) ? '0 : acc_r + CW'(1);
                end else begin
                    r_col <= acc_c + CW'(1);
                end
            end
            if (accept) begin
                r_s1_v <= 1'b1;
                // same column written this edge: take the new entry directly
                r_byp  <= consume && (r_s1_c == acc_c);
            end else if (consume) begin
                r_s1_v <= 1'b0;
            end
            if (consume) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= rd_eff[2*PW-1:PW];
                r_win[1][2] <= rd_eff[PW-1:0];
                r_win[2][2] <= r_s1_pix;
                r_em_busy   <= has_a && has_b;
            end else if (r_em_busy && en && em_last) begin
                r_em_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= {i_in_data.in_blue, i_in_data.in_green, i_in_data.in_red};
            r_s1_r   <= acc_r;
            r_s1_c   <= acc_c;
            r_rd     <= mem[acc_c];
            r_byp_d  <= {rd_eff[PW-1:0], r_s1_pix};
        end
        if (consume) begin
            mem[r_s1_c] <= {rd_eff[PW-1:0], r_s1_pix};
        end
    end

    // output sequencer
    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_ea  <= a0;
            r_ea1 <= a1;
            r_eb  <= b0;
            r_eb0 <= b0;
            r_eb1 <= b1;
            r_er  <= r_s1_r;
            r_ec  <= r_s1_c;
        end else if (r_em_busy && en && !em_last) begin
            if (r_eb == r_eb1) begin
                r_eb <= r_eb0;
                r_ea <= r_ea + CW'(1);
            end else begin
                r_eb <= r_eb + CW'(1);
            end
        end
    end

    always_comb begin
        job.vld  = r_em_busy;
        job.row  = r_ea;
        job.col  = r_eb;
        job.last = em_last;
        job.oa   = 2'(r_ea + CW'(2) - r_er);
        job.ob   = 2'(r_eb + CW'(2) - r_ec);
    end

    w3f_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_job   (job),
        .i_win   (r_win),
        .o_valid (kern_v),
        .o_item  (o_out_data)
    );

    assign o_out_valid = kern_v;

endmodule

@@ design/w3f_kernel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3f_kernel
// Weighted sum pipeline: products, divide by 100, sum into the output register.
// ----------------------------------------------------------------------------
module w3f_kernel (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  w3f_pkg::t_job       i_job,
    input  w3f_pkg::t_win       i_win,
    output logic                o_valid,
    output w3f_pkg::t_out_item  o_item
);
    import w3f_pkg::*;

    logic                 r_p_v, r_q_v, r_o_v;
    t_job                 r_p_job, r_q_job;
    logic [PRODW-1:0]     r_prod [3][9];
    logic [CHW-1:0]       r_quot [3][9];
    logic [CHW-1:0]       n_sum  [3];
    logic [5:0]           n_wt   [9];
    t_out_item            r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_q_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= i_job.vld;
            r_q_v <= r_p_v;
            r_o_v <= r_q_v;
        end
    end

    always_comb begin
        for (int t = 0; t < 9; t++) begin
            n_wt[t] = weight(i_job.oa, i_job.ob, 2'(t/3), 2'(t%3));
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_sum[ch] = '0;
            for (int t = 0; t < 9; t++) begin
                n_sum[ch] = n_sum[ch] + r_quot[ch][t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_job <= i_job;
            r_q_job <= r_p_job;
            for (int ch = 0; ch < 3; ch++) begin
                for (int t = 0; t < 9; t++) begin
                    // cells outside the mask may hold never-written line data
                    r_prod[ch][t] <= (n_wt[t] == 6'd0) ? '0
                                   : {6'b0, i_win[t/3][t%3][ch*CHW +: CHW]}
                                     * {16'b0, n_wt[t]};
                    r_quot[ch][t] <= div100(r_prod[ch][t]);
                end
            end
            r_item.out_row   <= r_q_job.row;
            r_item.out_col   <= r_q_job.col;
            r_item.out_red   <= n_sum[0];
            r_item.out_green <= n_sum[1];
            r_item.out_blue  <= n_sum[2];
            r_item.burst_end <= r_q_job.last;
        end
    end

    assign o_valid = r_o_v;
    assign o_item  = r_item;

endmodule

@@ design/w3f_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3f_checker
// Port-level checks of the filter core, bound to the top level.
// ----------------------------------------------------------------------------
module w3f_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_out_valid,
    input  logic                    i_out_stall,
    input  w3f_pkg::t_out_item      o_out_data,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [31:0]             pwdata,
    input  logic [31:0]             prdata,
    input  logic                    pready
);
    import w3f_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output item changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_cfg_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && psel && penable && pwrite |=> prdata[FSW-1:0] == $past(pwdata[FSW-1:0]))
        else $error("frame size readback mismatch");

endmodule

bind weighted_3x3_pixel_filter_core w3f_checker u_w3f_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 weighted pixel filter: frames of random
// pixels at several sizes are streamed in, the filtered outputs are predicted
// in order and compared field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    import w3f_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic      psel;
    logic      penable;
    logic      pwrite;
    logic [AW-1:0] paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    weighted_3x3_pixel_filter_core dut (.*);

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // predictor state
    t_pix        line_top [MAX_DIM];
    t_pix        line_mid [MAX_DIM];
    t_pix        win [3][3];
    int unsigned cur_row, cur_col, frame_n;
    t_out_item   pending_pixels[$];
    int          n_errors;
    bit          idle_enable;

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $time, what);
        n_errors++;
    endtask

    function automatic int unsigned size_used(input int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic t_out_item filter_pixel(input int unsigned a, input int unsigned b,
                                               input int unsigned r, input int unsigned c);
        t_out_item o;
        int unsigned s [3];
        int unsigned x, y, v, wt;
        t_pix px;
        s = '{0, 0, 0};
        for (int di = 0; di < 3; di++) begin
            for (int dj = 0; dj < 3; dj++) begin
                x = a + di;
                y = b + dj;
                wt = (di == 0) ? (dj == 0 ? 60 : dj == 1 ? 3 : 0) :
                     (di == 1) ? (dj == 1 ? 30 : 3) : (dj == 0 ? 0 : dj == 1 ? 3 : 10);
                if (x <= r && y <= c && r - x < 3 && c - y < 3) begin
                    px = win[2 - (r - x)][2 - (c - y)];
                    for (int ch = 0; ch < 3; ch++) begin
                        v = px[16*ch +: 16];
                        s[ch] += (v * wt) / 100;
                    end
                end
            end
        end
        o.out_row   = a[CW-1:0];
        o.out_col   = b[CW-1:0];
        o.out_red   = s[0][15:0];
        o.out_green = s[1][15:0];
        o.out_blue  = s[2][15:0];
        o.burst_end = 1'b0;
        return o;
    endfunction

    function automatic void predict_pixel(input t_in_item it);
        int unsigned n, r, c, a0, a1, b0, b1;
        t_pix cur, top, mid;
        t_out_item o;
        n = size_used(frame_n);
        if (cur_row >= n || cur_col >= n) begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        cur = {it.in_blue, it.in_green, it.in_red};
        top = line_top[c];
        mid = line_mid[c];
        line_top[c] = mid;
        line_mid[c] = cur;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = cur;
        if (r == n - 1) begin
            a0 = (r >= 2) ? r - 2 : 0; a1 = r + 1;
        end else if (r >= 2) begin
            a0 = r - 2; a1 = r - 1;
        end else begin
            a0 = 0; a1 = 0;
        end
        if (c == n - 1) begin
            b0 = (c >= 2) ? c - 2 : 0; b1 = c + 1;
        end else if (c >= 2) begin
            b0 = c - 2; b1 = c - 1;
        end else begin
            b0 = 0; b1 = 0;
        end
        for (int unsigned a = a0; a < a1; a++) begin
            for (int unsigned b = b0; b < b1; b++) begin
                o = filter_pixel(a, b, r, c);
                o.burst_end = (a + 1 == a1 && b + 1 == b1);
                pending_pixels.push_back(o);
            end
        end
        cur_col = c + 1;
        if (cur_col >= n) begin
            cur_col = 0;
            cur_row = r + 1;
            if (cur_row >= n) cur_row = 0;
        end
    endfunction

    task automatic random_gap();
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    // valid stays high after the item so back-to-back items need no gap
    task automatic send_pixel(input t_in_item it);
        random_gap();
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_pixel(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (20) @(negedge i_clk);
    endtask

    // frame size change only when nothing is in flight
    task automatic write_frame_size(input int unsigned v);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_FRAME_SIZE; pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        frame_n = v & 32'h7ff;
        cur_row = 0;
        cur_col = 0;
    endtask

    function automatic t_in_item rand_pixel();
        t_in_item it;
        it.in_red   = $urandom();
        it.in_green = $urandom();
        it.in_blue  = $urandom();
        return it;
    endfunction

    task automatic send_frames(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_pixel(rand_pixel());
    endtask

    task automatic test_extremes();
        t_in_item it;
        write_frame_size(3);
        for (int i = 0; i < 9; i++) begin
            it = (i % 2) ? '1 : '0;
            if (i == 4) it = '1;
            send_pixel(it);
        end
        // all ones in red, then a single high bit in green and in blue
        for (int i = 0; i < 9; i++) begin
            it = '0;
            it.in_red   = 16'hffff;
            it.in_green = 16'h8000 >> i;
            it.in_blue  = 16'h0001 << i;
            send_pixel(it);
        end
    endtask

    task automatic test_tiny_frames();
        write_frame_size(1);
        send_frames(3);
        write_frame_size(2);
        send_frames(6);
        write_frame_size(0);   // behaves as size one
        send_frames(2);
    endtask

    task automatic test_restart_mid_frame();
        write_frame_size(5);
        send_frames(12);       // part of a frame, then restart
        write_frame_size(4);
        send_frames(16);
    endtask

    task automatic test_random_frames();
        int unsigned sz;
        for (int f = 0; f < 4; f++) begin
            sz = $urandom_range(3, 8);
            write_frame_size(sz);
            send_frames(sz * sz * $urandom_range(1, 2) - (f == 3 ? 2 : 0));
        end
    endtask

    task automatic test_large_sizes();
        // wide frames: only the first pixels of row zero, which complete no outputs
        write_frame_size(MAX_DIM);
        send_frames(6);
        write_frame_size(2047);  // clamps to the maximum
        send_frames(4);
        write_frame_size(9);
        send_frames(81);
    endtask

    task automatic test_no_idling();
        idle_enable = 1'b0;
        write_frame_size(7);
        send_frames(49);
    endtask

    // output side: random stall bursts and in-order comparison
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_enable && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected output %p", o_out_data));
            end else begin
                e = pending_pixels.pop_front();
                if (o_out_data.out_row !== e.out_row)
                    report_mismatch($sformatf("row %0d exp %0d", o_out_data.out_row, e.out_row));
                if (o_out_data.out_col !== e.out_col)
                    report_mismatch($sformatf("col %0d exp %0d", o_out_data.out_col, e.out_col));
                if (o_out_data.out_red !== e.out_red)
                    report_mismatch($sformatf("red %h exp %h at (%0d,%0d)",
                                    o_out_data.out_red, e.out_red, e.out_row, e.out_col));
                if (o_out_data.out_green !== e.out_green)
                    report_mismatch($sformatf("green %h exp %h at (%0d,%0d)",
                                    o_out_data.out_green, e.out_green, e.out_row, e.out_col));
                if (o_out_data.out_blue !== e.out_blue)
                    report_mismatch($sformatf("blue %h exp %h at (%0d,%0d)",
                                    o_out_data.out_blue, e.out_blue, e.out_row, e.out_col));
                if (o_out_data.burst_end !== e.burst_end)
                    report_mismatch($sformatf("burst_end %b exp %b at (%0d,%0d)",
                                    o_out_data.burst_end, e.burst_end, e.out_row, e.out_col));
            end
        end
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        n_errors = 0;
        idle_enable = 1'b1;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        frame_n = FRAME_SIZE_RST;
        cur_row = 0;
        cur_col = 0;
        for (int k = 0; k < 3; k++) win[k] = '{'0, '0, '0};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_tiny_frames();
        test_restart_mid_frame();
        test_random_frames();
        test_large_sizes();
        test_no_idling();
        drain();
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d outputs never arrived", pending_pixels.size()));
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/w3f_pkg.sv
design/w3f_kernel.sv
design/weighted_3x3_pixel_filter_core.sv
design/w3f_checker.sv
tb/tb.sv
